// ===== rtl/sclr_pkg.sv =====
`default_nettype none

package sclr_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int WEIGHT_BITS   = FRAC_BITS + 1;
  localparam int RATIO_BITS    = 24;
  localparam int DIM_BITS      = 8;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [DIM_BITS-1:0]    SRC_DIM_RST = 8'd128;
  localparam logic [RATIO_BITS-1:0]  RATIO_RST   = 24'h01_0000;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE  = WEIGHT_BITS'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_RATIO_X    = 2'd2,
    CFG_RATIO_Y    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic s3;
    logic s4;
    logic res;
  } blend_en_t;

endpackage

`default_nettype wire

// ===== rtl/sclr_cfg.sv =====
`default_nettype none

module sclr_cfg #(
  parameter int  MAX_SRC_DIM = 128,
  localparam int IdxBits     = $clog2(MAX_SRC_DIM)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  sclr_pkg::cfg_reg_e                  cfg_index_i,
  input  logic [sclr_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output logic [sclr_pkg::RATIO_BITS-1:0]     ratio_x_o,
  output logic [sclr_pkg::RATIO_BITS-1:0]     ratio_y_o,
  output logic [IdxBits-1:0]                  last_col_o,
  output logic [IdxBits-1:0]                  last_row_o
);
  import sclr_pkg::*;

  logic [DIM_BITS-1:0]   src_width_q;
  logic [DIM_BITS-1:0]   src_height_q;
  logic [RATIO_BITS-1:0] ratio_x_q;
  logic [RATIO_BITS-1:0] ratio_y_q;

  // A size of zero behaves as one, and one above the store behaves as the store size.
  function automatic logic [IdxBits-1:0] last_index(input logic [DIM_BITS-1:0] dim);
    logic [IdxBits-1:0] idx;
    if (dim == '0) begin
      idx = '0;
    end else if (int'(dim) > MAX_SRC_DIM) begin
      idx = IdxBits'(MAX_SRC_DIM - 1);
    end else begin
      idx = IdxBits'(dim - DIM_BITS'(1));
    end
    return idx;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SRC_DIM_RST;
      src_height_q <= SRC_DIM_RST;
      ratio_x_q    <= RATIO_RST;
      ratio_y_q    <= RATIO_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[DIM_BITS-1:0];
        CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[DIM_BITS-1:0];
        CFG_RATIO_X:    ratio_x_q    <= cfg_data_i[RATIO_BITS-1:0];
        CFG_RATIO_Y:    ratio_y_q    <= cfg_data_i[RATIO_BITS-1:0];
        default:        ;
      endcase
    end
  end

  assign ratio_x_o  = ratio_x_q;
  assign ratio_y_o  = ratio_y_q;
  assign last_col_o = last_index(src_width_q);
  assign last_row_o = last_index(src_height_q);

endmodule

`default_nettype wire

// ===== rtl/sclr_axis.sv =====
`default_nettype none

module sclr_axis #(
  parameter int POS_BITS = 34,
  parameter int IDX_BITS = 7
) (
  input  logic [POS_BITS-1:0]            pos_i,
  input  logic [IDX_BITS-1:0]            last_i,
  output logic [IDX_BITS-1:0]            c0_o,
  output logic [IDX_BITS-1:0]            c1_o,
  output logic [sclr_pkg::FRAC_BITS-1:0] frac_o
);
  import sclr_pkg::*;

  localparam int IntBits = POS_BITS - FRAC_BITS;
  localparam int CmpBits = (IntBits > IDX_BITS) ? IntBits : IDX_BITS;

  logic [CmpBits-1:0] int_ext;
  logic [CmpBits-1:0] last_ext;

  assign int_ext  = CmpBits'(pos_i[POS_BITS-1:FRAC_BITS]);
  assign last_ext = CmpBits'(last_i);
  assign frac_o   = pos_i[FRAC_BITS-1:0];

  always_comb begin
    if (int_ext > last_ext) begin
      c0_o = last_i;
    end else begin
      c0_o = IDX_BITS'(int_ext);
    end
    if (c0_o == last_i) begin
      c1_o = c0_o;
    end else begin
      c1_o = c0_o + IDX_BITS'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sclr_store.sv =====
`default_nettype none

module sclr_store #(
  parameter int  MAX_SRC_DIM = 128,
  parameter int  PIXEL_BITS  = 16,
  localparam int IdxBits     = $clog2(MAX_SRC_DIM),
  localparam int HalfBits    = (IdxBits > 1) ? IdxBits - 1 : 1,
  localparam int AddrBits    = HalfBits + IdxBits,
  localparam int Depth       = 1 << AddrBits
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [IdxBits-1:0]    wr_row_i,
  input  logic [IdxBits-1:0]    wr_col_i,
  input  logic [PIXEL_BITS-1:0] wr_data_i,
  input  logic                  rd_en_i,
  input  logic [IdxBits-1:0]    y0_i,
  input  logic [IdxBits-1:0]    y1_i,
  input  logic [IdxBits-1:0]    x0_i,
  input  logic [IdxBits-1:0]    x1_i,
  output logic [PIXEL_BITS-1:0] top_x0_o,
  output logic [PIXEL_BITS-1:0] top_x1_o,
  output logic [PIXEL_BITS-1:0] bot_x0_o,
  output logic [PIXEL_BITS-1:0] bot_x1_o
);

  // Even rows live in one bank and odd rows in the other, so the two rows of a
  // query never compete for a port.
  logic [PIXEL_BITS-1:0] even_mem [Depth];
  logic [PIXEL_BITS-1:0] odd_mem  [Depth];

  logic [IdxBits-1:0]    even_row;
  logic [IdxBits-1:0]    odd_row;
  logic [AddrBits-1:0]   wr_addr;
  logic [AddrBits-1:0]   even_addr0;
  logic [AddrBits-1:0]   even_addr1;
  logic [AddrBits-1:0]   odd_addr0;
  logic [AddrBits-1:0]   odd_addr1;

  logic [PIXEL_BITS-1:0] even_x0_q;
  logic [PIXEL_BITS-1:0] even_x1_q;
  logic [PIXEL_BITS-1:0] odd_x0_q;
  logic [PIXEL_BITS-1:0] odd_x1_q;
  logic                  y0_odd_q;
  logic                  y1_odd_q;

  assign even_row   = y0_i[0] ? y1_i : y0_i;
  assign odd_row    = y0_i[0] ? y0_i : y1_i;
  assign wr_addr    = {HalfBits'(wr_row_i >> 1), wr_col_i};
  assign even_addr0 = {HalfBits'(even_row >> 1), x0_i};
  assign even_addr1 = {HalfBits'(even_row >> 1), x1_i};
  assign odd_addr0  = {HalfBits'(odd_row >> 1), x0_i};
  assign odd_addr1  = {HalfBits'(odd_row >> 1), x1_i};

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_row_i[0]) begin
      even_mem[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      even_x0_q <= even_mem[even_addr0];
      even_x1_q <= even_mem[even_addr1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_row_i[0]) begin
      odd_mem[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      odd_x0_q <= odd_mem[odd_addr0];
      odd_x1_q <= odd_mem[odd_addr1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      y0_odd_q <= y0_i[0];
      y1_odd_q <= y1_i[0];
    end
  end

  assign top_x0_o = y0_odd_q ? odd_x0_q : even_x0_q;
  assign top_x1_o = y0_odd_q ? odd_x1_q : even_x1_q;
  assign bot_x0_o = y1_odd_q ? odd_x0_q : even_x0_q;
  assign bot_x1_o = y1_odd_q ? odd_x1_q : even_x1_q;

endmodule

`default_nettype wire

// ===== rtl/sclr_blend.sv =====
`default_nettype none

module sclr_blend #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk_i,
  input  sclr_pkg::blend_en_t            en_i,
  input  logic [PIXEL_BITS-1:0]          top_x0_i,
  input  logic [PIXEL_BITS-1:0]          top_x1_i,
  input  logic [PIXEL_BITS-1:0]          bot_x0_i,
  input  logic [PIXEL_BITS-1:0]          bot_x1_i,
  input  logic [sclr_pkg::FRAC_BITS-1:0] dx_i,
  input  logic [sclr_pkg::FRAC_BITS-1:0] dy_i,
  output logic [PIXEL_BITS-1:0]          pixel_o
);
  import sclr_pkg::*;

  localparam int RowBits  = PIXEL_BITS + FRAC_BITS;
  localparam int HProd    = PIXEL_BITS + WEIGHT_BITS;
  localparam int VProd    = RowBits + WEIGHT_BITS;
  localparam int SumBits  = PIXEL_BITS + 2 * FRAC_BITS;
  localparam logic [SumBits-1:0] RoundHalf = SumBits'(1) << (2 * FRAC_BITS - 1);

  logic [WEIGHT_BITS-1:0] wx0, wx1, wy0, wy1;
  logic [HProd-1:0]       ht0, ht1, hb0, hb1;
  logic [VProd-1:0]       vt, vb;
  logic [SumBits-1:0]     rounded;

  logic [RowBits-1:0]     top_q, bot_q;
  logic [FRAC_BITS-1:0]   dy_q;
  logic [SumBits-1:0]     sum_q;
  logic [PIXEL_BITS-1:0]  pixel_q;

  assign wx1 = {1'b0, dx_i};
  assign wx0 = WEIGHT_ONE - wx1;
  assign ht0 = top_x0_i * wx0;
  assign ht1 = top_x1_i * wx1;
  assign hb0 = bot_x0_i * wx0;
  assign hb1 = bot_x1_i * wx1;

  assign wy1 = {1'b0, dy_q};
  assign wy0 = WEIGHT_ONE - wy1;
  assign vt  = top_q * wy0;
  assign vb  = bot_q * wy1;

  assign rounded = sum_q + RoundHalf;

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      top_q <= RowBits'(ht0 + ht1);
      bot_q <= RowBits'(hb0 + hb1);
      dy_q  <= dy_i;
    end
    if (en_i.s4) begin
      sum_q <= SumBits'(vt + vb);
    end
    if (en_i.res) begin
      pixel_q <= rounded[SumBits-1 -: PIXEL_BITS];
    end
  end

  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

// ===== rtl/bilinear_image_scaler_unit.sv =====
// Bilinear image scaler.
// The input channel carries one command per transfer: a load writes pixel_in_i
// into the frame store at (load_row_i, load_col_i) and gives no result; a query
// maps (dest_col_i, dest_row_i) through the ratio registers and returns one
// blended pixel on the output channel. Results leave in command order.
// Configuration is written through the cfg channel, which is always ready; the
// user must write it only while no query is in flight, as the block does not
// enforce this. A query's result passes through the first stage, the bank
// reads, the horizontal and vertical blends and the output register before it
// is shown. One command is taken every cycle while in_stall_o is low; a query
// reads all four neighbours together from two row-interleaved dual-read banks.
// Loads are written in order with the reads of queries, so a query sees every load accepted before it.
// Reset empties the pipeline and restores the registers to a 128 by 128 source
// at a ratio of 1.0; the frame store is not cleared and must be loaded first.
// While the receiver stalls, the pipeline keeps filling behind the output
// register and in_stall_o rises only once every stage holds a query.
`default_nettype none

module bilinear_image_scaler_unit #(
  parameter int  MAX_SRC_DIM = 128,
  parameter int  MAX_DST_DIM = 1024,
  parameter int  PIXEL_BITS  = 16,
  localparam int IdxBits     = $clog2(MAX_SRC_DIM),
  localparam int DstBits     = $clog2(MAX_DST_DIM)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               cmd_i,
  input  logic [IdxBits-1:0]                 load_col_i,
  input  logic [IdxBits-1:0]                 load_row_i,
  input  logic [PIXEL_BITS-1:0]              pixel_in_i,
  input  logic [DstBits-1:0]                 dest_col_i,
  input  logic [DstBits-1:0]                 dest_row_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [PIXEL_BITS-1:0]              pixel_out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  sclr_pkg::cfg_reg_e                 cfg_index_i,
  input  logic [sclr_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import sclr_pkg::*;

  localparam int PosBits = DstBits + RATIO_BITS;

  logic [RATIO_BITS-1:0] ratio_x, ratio_y;
  logic [IdxBits-1:0]    last_col, last_row;
  logic [DstBits-1:0]    dcol, drow;
  logic [PosBits-1:0]    pos_x_d, pos_y_d;
  logic                  load_ok;

  logic                  o_free, r1, r2, r3, r4, rd_en;
  blend_en_t             blend_en;

  logic                  v1_q, s1_query_q, s1_wr_q, v2_q, v3_q, v4_q, out_valid_q;
  logic [IdxBits-1:0]    s1_col_q, s1_row_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [PosBits-1:0]    s1_pos_x_q, s1_pos_y_q;
  logic [FRAC_BITS-1:0]  s2_dx_q, s2_dy_q;

  logic [IdxBits-1:0]    x0, x1, y0, y1;
  logic [FRAC_BITS-1:0]  dx, dy;
  logic [PIXEL_BITS-1:0] top_x0, top_x1, bot_x0, bot_x1;

  sclr_cfg #(.MAX_SRC_DIM(MAX_SRC_DIM)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ratio_x_o   (ratio_x),
    .ratio_y_o   (ratio_y),
    .last_col_o  (last_col),
    .last_row_o  (last_row)
  );

  assign dcol    = (int'(dest_col_i) > MAX_DST_DIM - 1) ? DstBits'(MAX_DST_DIM - 1) : dest_col_i;
  assign drow    = (int'(dest_row_i) > MAX_DST_DIM - 1) ? DstBits'(MAX_DST_DIM - 1) : dest_row_i;
  assign pos_x_d = dcol * ratio_x;
  assign pos_y_d = drow * ratio_y;
  assign load_ok = (int'(load_col_i) < MAX_SRC_DIM) && (int'(load_row_i) < MAX_SRC_DIM);

  assign o_free     = !out_valid_q || !out_stall_i;
  assign r4         = !v4_q || o_free;
  assign r3         = !v3_q || r4;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || !s1_query_q || r2;
  assign in_stall_o = !r1;
  assign rd_en      = r2 && v1_q && s1_query_q;

  assign blend_en.s3  = r3 && v2_q;
  assign blend_en.s4  = r4 && v3_q;
  assign blend_en.res = o_free && v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      s1_query_q  <= 1'b0;
      s1_wr_q     <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (r1) begin
        v1_q       <= in_valid_i;
        s1_query_q <= (cmd_i == CMD_QUERY);
        s1_wr_q    <= (cmd_i == CMD_LOAD) && load_ok;
      end
      if (r2) begin
        v2_q <= v1_q && s1_query_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
      if (r4) begin
        v4_q <= v3_q;
      end
      if (o_free) begin
        out_valid_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      s1_col_q   <= load_col_i;
      s1_row_q   <= load_row_i;
      s1_pix_q   <= pixel_in_i;
      s1_pos_x_q <= pos_x_d;
      s1_pos_y_q <= pos_y_d;
    end
    if (rd_en) begin
      s2_dx_q <= dx;
      s2_dy_q <= dy;
    end
  end

  sclr_axis #(.POS_BITS(PosBits), .IDX_BITS(IdxBits)) u_axis_x (
    .pos_i  (s1_pos_x_q),
    .last_i (last_col),
    .c0_o   (x0),
    .c1_o   (x1),
    .frac_o (dx)
  );

  sclr_axis #(.POS_BITS(PosBits), .IDX_BITS(IdxBits)) u_axis_y (
    .pos_i  (s1_pos_y_q),
    .last_i (last_row),
    .c0_o   (y0),
    .c1_o   (y1),
    .frac_o (dy)
  );

  sclr_store #(.MAX_SRC_DIM(MAX_SRC_DIM), .PIXEL_BITS(PIXEL_BITS)) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (v1_q && s1_wr_q),
    .wr_row_i  (s1_row_q),
    .wr_col_i  (s1_col_q),
    .wr_data_i (s1_pix_q),
    .rd_en_i   (rd_en),
    .y0_i      (y0),
    .y1_i      (y1),
    .x0_i      (x0),
    .x1_i      (x1),
    .top_x0_o  (top_x0),
    .top_x1_o  (top_x1),
    .bot_x0_o  (bot_x0),
    .bot_x1_o  (bot_x1)
  );

  sclr_blend #(.PIXEL_BITS(PIXEL_BITS)) u_blend (
    .clk_i    (clk_i),
    .en_i     (blend_en),
    .top_x0_i (top_x0),
    .top_x1_i (top_x1),
    .bot_x0_i (bot_x0),
    .bot_x1_i (bot_x1),
    .dx_i     (s2_dx_q),
    .dy_i     (s2_dy_q),
    .pixel_o  (pixel_out_o)
  );

  assign out_valid_o = out_valid_q;

  a_load_never_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !s1_query_q |-> !in_stall_o)
    else $error("A load waiting in the first stage held off the input.");

  a_result_from_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v4_q))
    else $error("A result appeared without a query in the last stage.");

  a_neighbours_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && s1_query_q |-> x0 <= last_col && y0 <= last_row &&
                           (x1 == x0 || x1 == x0 + IdxBits'(1)) &&
                           (y1 == y0 || y1 == y0 + IdxBits'(1)))
    else $error("A neighbour lies outside the loaded image.");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && v4_q && v3_q && v2_q && v1_q && s1_query_q
    |-> in_stall_o)
    else $error("A transfer was taken while every stage was full and stalled.");

endmodule

`default_nettype wire
